// ===== src/positional_list_engine_core_macros.svh =====
// assertion helpers for the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ple_pkg.sv =====
package ple_pkg;

    // field widths
    localparam int OP_W  = 3;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 7;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // request op codes
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;
    localparam logic [OP_W-1:0] OP_LENGTH  = 3'd5;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    // decoded command kind
    typedef enum logic [2:0] {
        K_APPEND,
        K_INSERT,
        K_DELETE,
        K_REVERSE,
        K_READ,
        K_LENGTH,
        K_BAD
    } t_kind;

    // command passed from front to back
    typedef struct packed {
        t_kind                    kind;
        logic [POS_W-1:0]         pos;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;

    // back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

endpackage

// ===== src/ple_front.sv =====
module ple_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ple_pkg::OP_W-1:0]     i_op,
    input  logic [ple_pkg::POS_W-1:0]    i_position,
    input  logic signed [ple_pkg::VAL_W-1:0] i_value,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output ple_pkg::t_cmd                o_cmd
);
    import ple_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  w_take;

    // stage is free when empty or being drained
    assign o_ready = !r_valid || i_cmd_ready;
    assign w_take  = i_valid && o_ready;

    // classify the op code
    always_comb begin
        n_cmd.pos   = i_position;
        n_cmd.value = i_value;
        case (i_op)
            OP_APPEND:  n_cmd.kind = K_APPEND;
            OP_INSERT:  n_cmd.kind = K_INSERT;
            OP_DELETE:  n_cmd.kind = K_DELETE;
            OP_REVERSE: n_cmd.kind = K_REVERSE;
            OP_READ:    n_cmd.kind = K_READ;
            OP_LENGTH:  n_cmd.kind = K_LENGTH;
            default:    n_cmd.kind = K_BAD;
        endcase
    end

    // valid flag of the decode stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // decoded command register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ===== src/ple_queue.sv =====
module ple_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ple_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ple_pkg::t_cmd o_pop_cmd
);
    import ple_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] FULL_CNT = (PTR_W+1)'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_fill;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_fill != FULL_CNT;
    assign o_pop_valid  = r_fill != '0;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== src/ple_back.sv =====
`include "positional_list_engine_core_macros.svh"

module ple_back #(
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  ple_pkg::t_cmd                     i_cmd,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ple_pkg::ST_W-1:0]          o_status,
    output logic signed [ple_pkg::VAL_W-1:0]  o_value_out,
    output logic [ple_pkg::CNT_W-1:0]         o_index_out,
    output logic [ple_pkg::CNT_W-1:0]         o_length,
    output logic                              o_last
);
    import ple_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int WIDE_W = CNT_W + 2;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // list storage, kept physically; r_rev flips the logical order
    logic [VAL_W-1:0]   r_cells [DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_rev;
    logic               n_rev;
    t_back_state        r_state;
    t_back_state        n_state;
    logic [CNT_W-1:0]   r_rd_idx;
    logic [CNT_W-1:0]   n_rd_idx;

    // output register
    logic                r_out_valid;
    logic [ST_W-1:0]     r_status;
    logic [VAL_W-1:0]    r_value_out;
    logic [CNT_W-1:0]    r_index_out;
    logic [CNT_W-1:0]    r_out_len;
    logic                r_last;
    logic                out_load;
    logic [ST_W-1:0]     n_status;
    logic [VAL_W-1:0]    n_value_out;
    logic [CNT_W-1:0]    n_index_out;
    logic                n_last;

    logic                out_free;
    logic                cmd_pop;
    logic                do_ins;
    logic                do_del;
    logic                full;
    logic                ins_pos_ok;
    logic                del_pos_ok;
    logic [WIDE_W-1:0]   pos_w;
    logic [WIDE_W-1:0]   cnt_w;
    logic [WIDE_W-1:0]   eff_pos;
    logic [WIDE_W-1:0]   ins_q;
    logic [WIDE_W-1:0]   del_q;
    logic [WIDE_W-1:0]   rd_w;
    logic [WIDE_W-1:0]   rd_addr;
    logic [VAL_W-1:0]    rd_data;

    // handshake with the queue and the output side
    assign out_free    = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == BK_IDLE) && out_free;
    assign cmd_pop     = o_cmd_ready && i_cmd_valid;

    // position checks and logical-to-physical mapping
    assign pos_w      = WIDE_W'(i_cmd.pos);
    assign cnt_w      = WIDE_W'(r_count);
    assign full       = r_count >= DEPTH_C;
    assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
    assign del_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
    assign eff_pos    = (i_cmd.kind == K_APPEND) ? cnt_w + 1'b1 : pos_w;
    assign ins_q      = r_rev ? cnt_w + 1'b1 - eff_pos : eff_pos - 1'b1;
    assign del_q      = r_rev ? cnt_w - pos_w : pos_w - 1'b1;

    // single read port: delete in idle, walk position in read-out
    assign rd_w    = WIDE_W'(r_rd_idx);
    assign rd_addr = (r_state == BK_READ) ? (r_rev ? cnt_w - rd_w : rd_w - 1'b1) : del_q;
    assign rd_data = r_cells[rd_addr[IDX_W-1:0]];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (cmd_pop && i_cmd.kind == K_READ && r_count != '0) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (out_free && r_rd_idx == r_count) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // operation execution and result values
    always_comb begin
        out_load    = 1'b0;
        n_status    = ST_OK;
        n_value_out = '0;
        n_index_out = '0;
        n_last      = 1'b1;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        n_rev       = r_rev;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        case (r_state)
            BK_IDLE: begin
                if (cmd_pop) begin
                    out_load = 1'b1;
                    case (i_cmd.kind)
                        K_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                do_ins      = 1'b1;
                                n_count     = r_count + 1'b1;
                                n_index_out = r_count + 1'b1;
                            end
                        end
                        K_INSERT: begin
                            if (!ins_pos_ok) begin
                                n_status = ST_BADPOS;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                do_ins      = 1'b1;
                                n_count     = r_count + 1'b1;
                                n_index_out = i_cmd.pos[CNT_W-1:0];
                            end
                        end
                        K_DELETE: begin
                            if (!del_pos_ok) begin
                                n_status = ST_BADPOS;
                            end else begin
                                do_del      = 1'b1;
                                n_count     = r_count - 1'b1;
                                n_value_out = rd_data;
                                n_index_out = i_cmd.pos[CNT_W-1:0];
                            end
                        end
                        K_REVERSE: begin
                            n_rev = !r_rev;
                        end
                        K_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                out_load = 1'b0;
                                n_rd_idx = CNT_W'(1);
                            end
                        end
                        K_LENGTH: begin
                            n_status = ST_OK;
                        end
                        default: begin
                            n_status = ST_BADPOS;
                        end
                    endcase
                end
            end
            BK_READ: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_value_out = rd_data;
                    n_index_out = r_rd_idx;
                    n_last      = r_rd_idx == r_count;
                    n_rd_idx    = r_rd_idx + 1'b1;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rev    <= n_rev;
            r_rd_idx <= n_rd_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status    <= n_status;
            r_value_out <= n_value_out;
            r_index_out <= n_index_out;
            r_out_len   <= n_count;
            r_last      <= n_last;
        end
    end

    // row of cells, each shifting from its neighbor on insert or delete
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam logic [WIDE_W-1:0] K_IDX = WIDE_W'(k);
        logic [VAL_W-1:0] w_below;
        logic [VAL_W-1:0] w_above;

        if (k == 0) begin : g_first
            assign w_below = r_cells[k];
        end else begin : g_rest
            assign w_below = r_cells[k-1];
        end

        if (k == DEPTH - 1) begin : g_top
            assign w_above = r_cells[k];
        end else begin : g_lower
            assign w_above = r_cells[k+1];
        end

        always_ff @(posedge i_clk) begin
            if (do_ins) begin
                if (ins_q < K_IDX) begin
                    r_cells[k] <= w_below;
                end else if (ins_q == K_IDX) begin
                    r_cells[k] <= i_cmd.value;
                end
            end else if (do_del && del_q <= K_IDX) begin
                r_cells[k] <= w_above;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = $signed(r_value_out);
    assign o_index_out = r_index_out;
    assign o_length    = r_out_len;
    assign o_last      = r_last;

    // checks
    `PLE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)
    `PLE_ASSERT_IMP(a_walk_range, i_clk, i_rst_n, r_state == BK_READ, r_rd_idx != '0 && r_rd_idx <= r_count)
    `PLE_ASSERT_NXT(a_single_result, i_clk, i_rst_n, cmd_pop && i_cmd.kind != K_READ, r_out_valid && r_last)
    `PLE_ASSERT_NXT(a_walk_done, i_clk, i_rst_n, r_state == BK_READ && out_free && r_rd_idx == r_count, r_state == BK_IDLE && r_out_valid && r_last)

endmodule

// ===== src/positional_list_engine_core.sv =====
// channel   | valid    | ready    | payload
// request   | i_valid  | o_ready  | i_op, i_position, i_value
// result    | o_valid  | i_ready  | o_status, o_value_out, o_index_out, o_length, o_last
//
// append, insert, delete, reverse, length and unknown ops give one result in the cycle after
// the back pops them; a request passes the decode register and the queue before the back
// read-out walks the entries through the back's single read port, one result per entry
// reverse flips an order flag; insert and delete shift the cell row
// reset clears the length, the order flag and all valid flags; the cells are not cleared
// a stalled result holds the back; the two-entry queue lets the front take requests until full
module positional_list_engine_core #(
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ple_pkg::OP_W-1:0]          i_op,
    input  logic [ple_pkg::POS_W-1:0]         i_position,
    input  logic signed [ple_pkg::VAL_W-1:0]  i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ple_pkg::ST_W-1:0]          o_status,
    output logic signed [ple_pkg::VAL_W-1:0]  o_value_out,
    output logic [ple_pkg::CNT_W-1:0]         o_index_out,
    output logic [ple_pkg::CNT_W-1:0]         o_length,
    output logic                              o_last
);
    import ple_pkg::*;

    logic  dec_valid;
    logic  dec_ready;
    t_cmd  dec_cmd;
    logic  q_valid;
    logic  q_ready;
    t_cmd  q_cmd;

    // request decode
    ple_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_cmd_valid (dec_valid),
        .i_cmd_ready (dec_ready),
        .o_cmd       (dec_cmd)
    );

    // command queue
    ple_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (dec_valid),
        .o_push_ready (dec_ready),
        .i_push_cmd   (dec_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    // list execution
    ple_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_index_out (o_index_out),
        .o_length    (o_length),
        .o_last      (o_last)
    );

endmodule
